[rtl/core/max_window_pressure_range_macros.svh]
// Assertion macros for the windowed pressure range block.
// Used by the top level; relies on clk_i and rst_ni in the including scope.
`ifndef MAX_WINDOW_PRESSURE_RANGE_MACROS_SVH
`define MAX_WINDOW_PRESSURE_RANGE_MACROS_SVH

`ifndef ASSERT_OFF
`define MWPR_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define MWPR_ASSERT_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define MWPR_ASSERT(name, prop, msg)
`define MWPR_ASSERT_NEVER(name, cond, msg)
`endif

`endif

[rtl/core/mwpr_pkg.sv]
// Shared constants, register indexes and controller/datapath structs
// for the windowed pressure range block. No dependencies.
package mwpr_pkg;

  localparam int MAX_WINDOW = 64;
  localparam int ADDR_W     = $clog2(MAX_WINDOW);
  localparam int WIN_W      = 7;
  localparam int LEN_W      = 16;
  localparam int SAMPLE_W   = 18;
  localparam int DELTA_W    = 17;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_STEPS   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEPS_PER_TRAJ = 1'd1;

  localparam logic [WIN_W-1:0]   WINDOW_RST = 7'd2;
  localparam logic [LEN_W-1:0]   LEN_RST    = 16'd64;
  localparam logic [WIN_W-1:0]   MIN_WINDOW = 7'd2;
  localparam logic [WIN_W-1:0]   MAX_WIN_V  = WIN_W'(MAX_WINDOW);
  // 1200 hPa in 1/64 hPa units
  localparam logic [DELTA_W-1:0] PMIN_START = 17'd76800;

  typedef struct packed {
    logic load;
    logic scan;
    logic finish;
  } mwpr_cmd_t;

  typedef struct packed {
    logic eval_next;
    logic scan_done;
    logic commit_blocked;
  } mwpr_status_t;

endpackage

[rtl/core/mwpr_ifs.sv]
// Valid/ready channel interfaces: sample input, result output, register writes.
// Depends on mwpr_pkg.
interface mwpr_sample_if import mwpr_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] pressure_sample;
  modport source (output valid, output pressure_sample, input ready);
  modport sink   (input valid, input pressure_sample, output ready);
endinterface

interface mwpr_delta_if import mwpr_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [DELTA_W-1:0] max_delta;
  modport source (output valid, output max_delta, input ready);
  modport sink   (input valid, input max_delta, output ready);
endinterface

interface mwpr_cfg_if import mwpr_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/core/mwpr_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mwpr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/mwpr_ctrl.sv]
// Controller: sequences sample load, window scan, drain and commit.
// Depends on mwpr_pkg.
module mwpr_ctrl import mwpr_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  mwpr_status_t status_i,
  output mwpr_cmd_t    cmd_o
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_DRAIN  = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d      = state_q;
    cmd_o        = '0;
    in_ready_o   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = status_i.eval_next ? ST_SCAN : ST_FINISH;
        end
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (status_i.scan_done) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // last read data lands this cycle
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        // hold while the previous result still waits for its transfer
        if (!status_i.commit_blocked) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[rtl/core/mwpr_datapath.sv]
// Datapath: window memory, min/max accumulation, best delta and result register.
// Depends on mwpr_pkg, mwpr_ifs and mwpr_ram.
module mwpr_datapath import mwpr_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  mwpr_cmd_t                  cmd_i,
  output mwpr_status_t               status_o,
  input  logic [WIN_W-1:0]           window_steps_i,
  input  logic [LEN_W-1:0]           steps_per_traj_i,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  mwpr_delta_if.source               result_o
);

  logic [LEN_W-1:0]    pos_q;
  logic [DELTA_W-1:0]  best_q;
  logic [ADDR_W-1:0]   newest_q;
  logic [ADDR_W-1:0]   cnt_q;
  logic [WIN_W-1:0]    w_q;
  logic                eval_q;
  logic                last_q;
  logic                rvalid_q;
  logic                out_valid_q;
  logic [DELTA_W-1:0]  out_data_q;
  logic [DELTA_W-1:0]  min_q;
  logic [DELTA_W-1:0]  max_q;

  logic [LEN_W-1:0]    len;
  logic [WIN_W-1:0]    w_sat;
  logic [WIN_W-1:0]    w_eff;
  logic [LEN_W:0]      pos_inc;
  logic                eval_now;
  logic                last_now;
  logic [ADDR_W-1:0]   waddr;
  logic [ADDR_W-1:0]   raddr;
  logic [SAMPLE_W-1:0] rdata;
  logic                rd_ok;
  logic [DELTA_W-1:0]  rd_mag;
  logic signed [DELTA_W:0] delta;
  logic                better;
  logic [DELTA_W-1:0]  best_next;
  logic                out_busy;

  // Effective trajectory and window lengths from the registers.
  always_comb begin
    len = (steps_per_traj_i == '0) ? LEN_W'(1) : steps_per_traj_i;
    if (window_steps_i > MAX_WIN_V) begin
      w_sat = MAX_WIN_V;
    end else if (window_steps_i < MIN_WINDOW) begin
      w_sat = MIN_WINDOW;
    end else begin
      w_sat = window_steps_i;
    end
    w_eff    = (LEN_W'(w_sat) > len) ? len[WIN_W-1:0] : w_sat;
    pos_inc  = {1'b0, pos_q} + (LEN_W+1)'(1);
    eval_now = pos_inc >= (LEN_W+1)'(w_eff);
    last_now = pos_inc >= {1'b0, len};
  end

  assign waddr = newest_q + ADDR_W'(1);
  assign raddr = newest_q - cnt_q;

  mwpr_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (MAX_WINDOW)
  ) u_window_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.load),
    .waddr_i (waddr),
    .wdata_i (sample_i),
    .re_i    (cmd_i.scan),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Missing samples (zero or negative) take no part in min/max.
  assign rd_ok  = !rdata[SAMPLE_W-1] && (rdata != '0);
  assign rd_mag = rdata[DELTA_W-1:0];

  always_comb begin
    delta     = $signed({1'b0, max_q}) - $signed({1'b0, min_q});
    better    = eval_q && (delta > $signed({1'b0, best_q}));
    best_next = better ? delta[DELTA_W-1:0] : best_q;
  end

  assign out_busy = out_valid_q && !result_o.ready;

  always_comb begin
    status_o.eval_next      = eval_now;
    status_o.scan_done      = cnt_q == ADDR_W'(w_q - WIN_W'(1));
    status_o.commit_blocked = last_q && out_busy;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      best_q      <= '0;
      newest_q    <= '0;
      cnt_q       <= '0;
      w_q         <= WINDOW_RST;
      eval_q      <= 1'b0;
      last_q      <= 1'b0;
      rvalid_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      rvalid_q <= cmd_i.scan;
      if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.load) begin
        newest_q <= waddr;
        cnt_q    <= '0;
        w_q      <= w_eff;
        eval_q   <= eval_now;
        last_q   <= last_now;
      end
      if (cmd_i.scan) begin
        cnt_q <= cnt_q + ADDR_W'(1);
      end
      if (cmd_i.finish) begin
        if (last_q) begin
          out_valid_q <= 1'b1;
          best_q      <= '0;
          pos_q       <= '0;
        end else begin
          best_q <= best_next;
          pos_q  <= pos_inc[LEN_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      min_q <= PMIN_START;
      max_q <= '0;
    end else if (rvalid_q && rd_ok) begin
      if (rd_mag < min_q) begin
        min_q <= rd_mag;
      end
      if (rd_mag > max_q) begin
        max_q <= rd_mag;
      end
    end
    if (cmd_i.finish && last_q) begin
      out_data_q <= best_next;
    end
  end

  assign result_o.valid     = out_valid_q;
  assign result_o.max_delta = out_data_q;

endmodule

[rtl/core/max_window_pressure_range.sv]
// Windowed pressure range. Takes one pressure sample per transfer and, after the
// last sample of each trajectory, returns the greatest max-minus-min of valid
// samples over any window of W consecutive samples of that trajectory. The last
// MAX_WINDOW samples live in a single-port-read RAM that is scanned one entry
// per cycle, so a sample that closes a window goes through accept, W reads,
// drain and commit, any other sample through accept and commit. The result sits
// in an output register and does not stall input unless a trajectory ends again
// before the previous result is taken. No clearing pass is needed after reset.
// Register 0 is window_steps, register 1 is steps_per_trajectory; write them
// while the block is idle. Depends on mwpr_pkg, mwpr_ifs, mwpr_ctrl and
// mwpr_datapath.
`include "max_window_pressure_range_macros.svh"

module max_window_pressure_range import mwpr_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  mwpr_cfg_if.sink     cfg_i,
  mwpr_sample_if.sink  sample_i,
  mwpr_delta_if.source result_o
);

  logic [WIN_W-1:0] window_steps_q;
  logic [LEN_W-1:0] steps_per_traj_q;
  mwpr_cmd_t        cmd;
  mwpr_status_t     status;
  logic             in_ready;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_steps_q   <= WINDOW_RST;
      steps_per_traj_q <= LEN_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_WINDOW_STEPS:   window_steps_q   <= cfg_i.data[WIN_W-1:0];
        REG_STEPS_PER_TRAJ: steps_per_traj_q <= cfg_i.data[LEN_W-1:0];
        default: begin
          window_steps_q <= window_steps_q;
        end
      endcase
    end
  end

  assign sample_i.ready = in_ready;

  mwpr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (sample_i.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  mwpr_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .window_steps_i   (window_steps_q),
    .steps_per_traj_i (steps_per_traj_q),
    .sample_i         (sample_i.pressure_sample),
    .result_o         (result_o)
  );

  `MWPR_ASSERT(a_scan_blocks_input, cmd.scan |-> !in_ready, "input ready during window scan")
  `MWPR_ASSERT(a_result_from_commit, $rose(result_o.valid) |-> $past(cmd.finish), "result without commit")
  `MWPR_ASSERT_NEVER(a_load_while_busy, cmd.load && (cmd.scan || cmd.finish), "load overlaps work")

endmodule

[tb/sv/mwpr_range_checker.sv]
`timescale 1ns / 100ps
// Checker for the windowed pressure range block: watches the register, sample
// and result channels, predicts each trajectory's max_delta and compares it.
// Depends on mwpr_pkg.
module mwpr_range_checker import mwpr_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  input  logic                       cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                       sample_valid_i,
  input  logic                       sample_ready_i,
  input  logic signed [SAMPLE_W-1:0] pressure_sample_i,
  input  logic                       delta_valid_i,
  input  logic                       delta_ready_i,
  input  logic [DELTA_W-1:0]         max_delta_i,
  output int                         fail_count_o,
  output int                         deltas_pending_o,
  output int                         deltas_checked_o
);

  logic [WIN_W-1:0]           window_steps_q;
  logic [LEN_W-1:0]           traj_steps_q;
  logic signed [SAMPLE_W-1:0] recent_samples [MAX_WINDOW];
  logic [LEN_W-1:0]           sample_pos_q;
  int                         best_span_q;
  logic [DELTA_W-1:0]         expected_deltas [$];

  int                 fails;
  int                 checked;
  int                 pending_q;
  bit                 traj_done;
  logic [DELTA_W-1:0] predicted_delta;
  logic [DELTA_W-1:0] oldest_delta;

  assign fail_count_o     = fails;
  assign deltas_pending_o = pending_q;
  assign deltas_checked_o = checked;

  // Shift one sample in, evaluate the window that closes on it and close the
  // trajectory once its last position is reached.
  task automatic predict_pressure_range(input logic signed [SAMPLE_W-1:0] sample,
                                        output bit closes,
                                        output logic [DELTA_W-1:0] delta);
    int unsigned traj_len;
    int unsigned win_len;
    int          pmin;
    int          pmax;
    int          v;
    traj_len = (traj_steps_q == '0) ? 1 : traj_steps_q;
    win_len  = window_steps_q;
    if (win_len > MAX_WINDOW) win_len = MAX_WINDOW;
    if (win_len < MIN_WINDOW) win_len = MIN_WINDOW;
    if (win_len > traj_len) win_len = traj_len;
    for (int k = MAX_WINDOW - 1; k > 0; k--) recent_samples[k] = recent_samples[k-1];
    recent_samples[0] = sample;
    closes = 1'b0;
    delta  = '0;
    if (sample_pos_q + 1 >= win_len) begin
      pmin = PMIN_START;
      pmax = 0;
      for (int k = 0; k < win_len; k++) begin
        v = recent_samples[k];
        // skip missing values
        if (v > 0 && v < pmin) pmin = v;
        if (v > 0 && v > pmax) pmax = v;
      end
      if (pmax - pmin > best_span_q) best_span_q = pmax - pmin;
    end
    if (sample_pos_q + 1 >= traj_len) begin
      closes       = 1'b1;
      delta        = best_span_q[DELTA_W-1:0];
      sample_pos_q = '0;
      best_span_q  = 0;
    end else begin
      sample_pos_q = sample_pos_q + 1'b1;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_steps_q = WINDOW_RST;
      traj_steps_q   = LEN_RST;
      sample_pos_q   = '0;
      best_span_q    = 0;
      foreach (recent_samples[k]) recent_samples[k] = '0;
      expected_deltas.delete();
      fails     = 0;
      checked   = 0;
      pending_q <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_WINDOW_STEPS:   window_steps_q = cfg_data_i[WIN_W-1:0];
          REG_STEPS_PER_TRAJ: traj_steps_q   = cfg_data_i[LEN_W-1:0];
          default: ;
        endcase
      end
      if (sample_valid_i && sample_ready_i) begin
        predict_pressure_range(pressure_sample_i, traj_done, predicted_delta);
        if (traj_done) expected_deltas.push_back(predicted_delta);
      end
      if (delta_valid_i && delta_ready_i) begin
        if (expected_deltas.size() == 0) begin
          fails++;
          $display("%0t: unexpected max_delta transfer: expected none, actual %0d",
                   $time, max_delta_i);
        end else begin
          oldest_delta = expected_deltas.pop_front();
          checked++;
          if (max_delta_i !== oldest_delta) begin
            fails++;
            $display("%0t: max_delta mismatch: expected %0d, actual %0d",
                     $time, oldest_delta, max_delta_i);
          end
        end
      end
      pending_q <= expected_deltas.size();
    end
  end

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 100ps
// Top of the windowed pressure range testbench: clock, reset, register writes,
// sample and result-side stimulus, verdict. Depends on mwpr_pkg, mwpr_ifs,
// mwpr_range_checker and the block itself.
module tb;
  import mwpr_pkg::*;

  localparam int RANDOM_SAMPLES = 1650;
  localparam int SETTLE_CYCLES  = 80;

  logic clk;
  logic rst_n;
  bit   steady;
  int   samples_sent;
  int   settings_written;
  int   fail_count;
  int   deltas_pending;
  int   deltas_checked;

  mwpr_cfg_if    cfg_bus ();
  mwpr_sample_if sample_bus ();
  mwpr_delta_if  delta_bus ();

  max_window_pressure_range u_dut (
    .clk_i    (clk),
    .rst_ni   (rst_n),
    .cfg_i    (cfg_bus),
    .sample_i (sample_bus),
    .result_o (delta_bus)
  );

  mwpr_range_checker u_checker (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .cfg_valid_i       (cfg_bus.valid),
    .cfg_ready_i       (cfg_bus.ready),
    .cfg_index_i       (cfg_bus.index),
    .cfg_data_i        (cfg_bus.data),
    .sample_valid_i    (sample_bus.valid),
    .sample_ready_i    (sample_bus.ready),
    .pressure_sample_i (sample_bus.pressure_sample),
    .delta_valid_i     (delta_bus.valid),
    .delta_ready_i     (delta_bus.ready),
    .max_delta_i       (delta_bus.max_delta),
    .fail_count_o      (fail_count),
    .deltas_pending_o  (deltas_pending),
    .deltas_checked_o  (deltas_checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #40_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // Result side: random stall before each transfer, none in steady phases.
  initial begin : result_sink
    int stall;
    delta_bus.ready <= 1'b0;
    @(posedge rst_n);
    @(posedge clk);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 14);
      if (stall > 0) begin
        delta_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      delta_bus.ready <= 1'b1;
      do @(posedge clk); while (!delta_bus.valid);
    end
  end

  task automatic send_sample(input logic signed [SAMPLE_W-1:0] value);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      sample_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_bus.valid           <= 1'b1;
    sample_bus.pressure_sample <= value;
    do @(posedge clk); while (!sample_bus.ready);
    samples_sent++;
  endtask

  // Drop valid, wait for every outstanding result, then let any window scan drain.
  task automatic settle();
    sample_bus.valid <= 1'b0;
    do @(posedge clk); while (deltas_pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write both registers back to back; valid stays high across the two transfers.
  task automatic reconfigure(input logic [CFG_DATA_W-1:0] win_word,
                             input logic [CFG_DATA_W-1:0] len_word);
    settle();
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= REG_WINDOW_STEPS;
    cfg_bus.data  <= win_word;
    do @(posedge clk); while (!cfg_bus.ready);
    cfg_bus.index <= REG_STEPS_PER_TRAJ;
    cfg_bus.data  <= len_word;
    do @(posedge clk); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    settings_written++;
  endtask

  function automatic logic signed [SAMPLE_W-1:0] random_pressure();
    int mag;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return SAMPLE_W'($urandom_range(25600, 76800));
      6:                return SAMPLE_W'($urandom_range(76801, 131071));
      7: begin
        mag = $urandom_range(0, 131072);
        return SAMPLE_W'(-mag);
      end
      8: begin
        case ($urandom_range(0, 5))
          0:       return SAMPLE_W'(131071);
          1:       return SAMPLE_W'(-131072);
          2:       return SAMPLE_W'(0);
          3:       return SAMPLE_W'(1);
          4:       return SAMPLE_W'(76800);
          default: return SAMPLE_W'(76799);
        endcase
      end
      default:          return SAMPLE_W'($urandom());
    endcase
  endfunction

  initial begin : stimulus
    int                    len;
    int                    win;
    int                    eff_len;
    int                    count;
    int                    target;
    logic [CFG_DATA_W-1:0] win_word;
    rst_n                      <= 1'b0;
    cfg_bus.valid              <= 1'b0;
    cfg_bus.index              <= REG_WINDOW_STEPS;
    cfg_bus.data               <= '0;
    sample_bus.valid           <= 1'b0;
    sample_bus.pressure_sample <= '0;
    steady           = 1'b0;
    samples_sent     = 0;
    settings_written = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // field extremes and missing values in one short trajectory
    reconfigure(16'd2, 16'd4);
    send_sample(SAMPLE_W'(131071));
    send_sample(SAMPLE_W'(-131072));
    send_sample(SAMPLE_W'(0));
    send_sample(SAMPLE_W'(1));
    // window longer than the trajectory
    reconfigure(16'd5, 16'd3);
    send_sample(SAMPLE_W'(76800));
    send_sample(SAMPLE_W'(76801));
    send_sample(SAMPLE_W'(1));
    // window register below two, every sample missing
    reconfigure(16'd0, 16'd2);
    send_sample(SAMPLE_W'(-5));
    send_sample(SAMPLE_W'(0));
    // one-sample trajectories against the starting minimum
    reconfigure(16'd127, 16'd1);
    send_sample(SAMPLE_W'(80000));
    send_sample(SAMPLE_W'(50000));
    // zero length acts as one
    reconfigure(16'd1, 16'd0);
    send_sample(SAMPLE_W'(131071));
    // longest trajectory, then shorten it while it is under way
    reconfigure(16'hFF82, 16'hFFFF);
    send_sample(SAMPLE_W'(60000));
    send_sample(SAMPLE_W'(70000));
    send_sample(SAMPLE_W'(65000));
    reconfigure(16'd64, 16'd2);
    send_sample(SAMPLE_W'(40000));
    // widen the window halfway through a trajectory
    reconfigure(16'd2, 16'd6);
    send_sample(SAMPLE_W'(64000));
    send_sample(SAMPLE_W'(64100));
    send_sample(SAMPLE_W'(-1));
    reconfigure(16'd3, 16'd6);
    send_sample(SAMPLE_W'(63000));
    send_sample(SAMPLE_W'(0));
    send_sample(SAMPLE_W'(66000));

    target = samples_sent + RANDOM_SAMPLES;
    while (samples_sent < target) begin
      steady = ($urandom_range(0, 4) == 0);
      case ($urandom_range(0, 19))
        0:       len = 0;
        1:       len = 1;
        2:       len = 65535;
        3, 4:    len = $urandom_range(25, 100);
        default: len = $urandom_range(2, 24);
      endcase
      case ($urandom_range(0, 9))
        0:       win = $urandom_range(0, 1);
        1:       win = $urandom_range(65, 127);
        2:       win = MAX_WINDOW;
        default: win = $urandom_range(2, 20);
      endcase
      win_word = CFG_DATA_W'(win);
      // upper bits of the word lie outside the window register
      if ($urandom_range(0, 7) == 0) begin
        win_word[CFG_DATA_W-1:WIN_W] = (CFG_DATA_W-WIN_W)'($urandom());
      end
      reconfigure(win_word, CFG_DATA_W'(len));
      eff_len = (len == 0) ? 1 : len;
      if (len == 65535) count = $urandom_range(1, 40);
      else if ($urandom_range(0, 3) == 0) count = $urandom_range(1, 3 * eff_len);
      else count = eff_len * $urandom_range(1, 4);
      repeat (count) send_sample(random_pressure());
    end
    steady = 1'b0;
    settle();

    $display("Covered %0d pressure samples over %0d register settings, %0d ranges checked",
             samples_sent, settings_written, deltas_checked);
    if (fail_count == 0 && deltas_pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
